[rtl/mvrm_pkg.sv]
// shared constants, codes and control types of the resampling mixer
// used by every file of the block; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package mvrm_pkg;

    localparam int VOICES       = 8;
    localparam int VIDX_W       = 3;
    localparam int SAMPLE_WORDS = 65536;
    localparam int ADDR_W       = 16;
    localparam int SAMPLE_W     = 16;
    localparam int FRAC_BITS    = 16;
    localparam int LEN_W        = 17;
    localparam int FRAMES_W     = 17;
    localparam int POS_W        = 33;
    localparam int STEP_W       = 32;
    localparam int GAIN_W       = 7;
    localparam int GAIN_MAX     = 100;
    localparam int RATE_W       = 18;
    localparam int RATE_RESET   = 44100;
    localparam int DIVD_W       = RATE_W + FRAC_BITS;
    localparam int DIVS_W       = 18;
    localparam int DCNT_W       = 6;
    localparam int PROD_W       = 34;
    localparam int GPROD_W      = 40;
    localparam int Y_W          = 22;
    localparam int RECIP_M      = 5368710;
    localparam int RECIP_W      = 45;
    localparam int RECIP_SH     = 29;
    localparam int CONTRIB_W    = 17;
    localparam int ACC_W        = 20;
    localparam int OUT_W        = 16;
    localparam int MASK_W       = 8;
    localparam int OUT_MAX      = 32767;
    localparam int OUT_MIN      = -32768;

    typedef enum logic [2:0] {
        MODE_WRITE,
        MODE_START,
        MODE_VOLUME,
        MODE_STOP,
        MODE_PAUSE,
        MODE_RESUME,
        MODE_MIX,
        MODE_NONE
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_NO_FREE,
        ST_NOT_ACTIVE
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DIV_STEP,
        S_MOD_GO,
        S_DIV_MOD,
        S_COMMIT,
        S_CHK,
        S_RD0,
        S_RD1,
        S_CAP,
        S_PROD,
        S_GAIN,
        S_RECIP,
        S_ACC,
        S_ADV,
        S_RESP
    } ctrl_state_t;

    typedef struct packed {
        logic in_ready;
        logic latch;
        logic mem_wr;
        logic voice_cmd;
        logic div_start;
        logic div_mod;
        logic step_load;
        logic stepm_load;
        logic commit;
        logic mix_init;
        logic rd_en;
        logic word_sel;
        logic cap_s0;
        logic cap_s1;
        logic prod;
        logic gain;
        logic recip;
        logic acc;
        logic side_set;
        logic adv;
        logic voice_next;
        logic resp_load;
    } mvrm_cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  no_free;
        logic  div_done;
        logic  loop_mod;
        logic  voice_live;
        logic  voice_stereo;
        logic  side;
        logic  last_voice;
        logic  out_busy;
    } mvrm_stat_t;

endpackage

`default_nettype wire

[rtl/mvrm_if.sv]
// item channels and configuration write channel of the mixer
// depends on mvrm_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface mvrm_in_if;
    logic                                valid;
    logic                                ready;
    logic [2:0]                          mode;
    logic [mvrm_pkg::ADDR_W-1:0]         address;
    logic signed [mvrm_pkg::SAMPLE_W-1:0] sample_value;
    logic [mvrm_pkg::LEN_W-1:0]          length_words;
    logic                                stereo;
    logic [mvrm_pkg::RATE_W-1:0]         source_rate;
    logic                                loop_enable;
    logic [mvrm_pkg::GAIN_W-1:0]         volume;
    logic [mvrm_pkg::VIDX_W-1:0]         voice;

    modport source (output valid, mode, address, sample_value, length_words, stereo,
                    source_rate, loop_enable, volume, voice, input ready);
    modport sink (input valid, mode, address, sample_value, length_words, stereo,
                  source_rate, loop_enable, volume, voice, output ready);
endinterface

interface mvrm_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [mvrm_pkg::OUT_W-1:0]   left_sample;
    logic signed [mvrm_pkg::OUT_W-1:0]   right_sample;
    logic [mvrm_pkg::VIDX_W-1:0]         slot;
    logic [1:0]                          status;
    logic [mvrm_pkg::MASK_W-1:0]         playing_mask;

    modport source (output valid, left_sample, right_sample, slot, status, playing_mask,
                    input ready);
    modport sink (input valid, left_sample, right_sample, slot, status, playing_mask,
                  output ready);
endinterface

interface mvrm_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [mvrm_pkg::RATE_W-1:0]   output_rate;

    modport source (output valid, output_rate, input ready);
    modport sink (input valid, output_rate, output ready);
endinterface

`default_nettype wire

[rtl/mvrm_div.sv]
// restoring divider, one quotient bit per cycle, for the voice step and its wrap
// depends on mvrm_pkg
`timescale 1ns / 1ps
`default_nettype none

module mvrm_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [mvrm_pkg::DIVD_W-1:0]   dividend,
    input  wire logic [mvrm_pkg::DIVS_W-1:0]   divisor,
    output logic      [mvrm_pkg::DIVD_W-1:0]   quotient,
    output logic      [mvrm_pkg::DIVS_W-1:0]   remainder,
    output logic                               done
);

    logic [mvrm_pkg::DCNT_W-1:0] cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [mvrm_pkg::DIVD_W-1:0] quo_reg, quo_next;
    logic [mvrm_pkg::DIVS_W-1:0] rem_reg, rem_next;
    logic [mvrm_pkg::DIVS_W-1:0] dvs_reg, dvs_next;
    logic [mvrm_pkg::DIVS_W:0]   shifted;
    logic [mvrm_pkg::DIVS_W:0]   diff;
    logic                        ge;

    assign shifted = {rem_reg, quo_reg[mvrm_pkg::DIVD_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign ge      = shifted >= {1'b0, dvs_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            cnt_next  = mvrm_pkg::DCNT_W'(mvrm_pkg::DIVD_W);
            busy_next = 1'b1;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[mvrm_pkg::DIVD_W-2:0], ge};
            rem_next = ge ? diff[mvrm_pkg::DIVS_W-1:0] : shifted[mvrm_pkg::DIVS_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == mvrm_pkg::DCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

`default_nettype wire

[rtl/mvrm_ctrl.sv]
// sequencer of the mixer: decodes each item and steps the datapath through it
// depends on mvrm_pkg
`timescale 1ns / 1ps
`default_nettype none

module mvrm_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire mvrm_pkg::mvrm_stat_t stat,
    output mvrm_pkg::mvrm_cmd_t       cmd
);

    mvrm_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mvrm_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mvrm_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = mvrm_pkg::S_DECODE;
                end
            end
            mvrm_pkg::S_DECODE:
            begin
                case (stat.mode)
                    mvrm_pkg::MODE_START:
                    begin
                        state_next = stat.no_free ? mvrm_pkg::S_RESP : mvrm_pkg::S_DIV_STEP;
                    end
                    mvrm_pkg::MODE_MIX:
                    begin
                        state_next = mvrm_pkg::S_CHK;
                    end
                    default:
                    begin
                        state_next = mvrm_pkg::S_RESP;
                    end
                endcase
            end
            mvrm_pkg::S_DIV_STEP:
            begin
                if (stat.div_done)
                begin
                    state_next = stat.loop_mod ? mvrm_pkg::S_MOD_GO : mvrm_pkg::S_COMMIT;
                end
            end
            mvrm_pkg::S_MOD_GO:
            begin
                state_next = mvrm_pkg::S_DIV_MOD;
            end
            mvrm_pkg::S_DIV_MOD:
            begin
                if (stat.div_done)
                begin
                    state_next = mvrm_pkg::S_COMMIT;
                end
            end
            mvrm_pkg::S_COMMIT:
            begin
                state_next = mvrm_pkg::S_RESP;
            end
            mvrm_pkg::S_CHK:
            begin
                if (stat.voice_live)
                begin
                    state_next = mvrm_pkg::S_RD0;
                end
                else if (stat.last_voice)
                begin
                    state_next = mvrm_pkg::S_RESP;
                end
            end
            mvrm_pkg::S_RD0:   state_next = mvrm_pkg::S_RD1;
            mvrm_pkg::S_RD1:   state_next = mvrm_pkg::S_CAP;
            mvrm_pkg::S_CAP:   state_next = mvrm_pkg::S_PROD;
            mvrm_pkg::S_PROD:  state_next = mvrm_pkg::S_GAIN;
            mvrm_pkg::S_GAIN:  state_next = mvrm_pkg::S_RECIP;
            mvrm_pkg::S_RECIP: state_next = mvrm_pkg::S_ACC;
            mvrm_pkg::S_ACC:
            begin
                state_next = (stat.voice_stereo && !stat.side) ? mvrm_pkg::S_RD0
                                                                : mvrm_pkg::S_ADV;
            end
            mvrm_pkg::S_ADV:
            begin
                state_next = stat.last_voice ? mvrm_pkg::S_RESP : mvrm_pkg::S_CHK;
            end
            mvrm_pkg::S_RESP:
            begin
                if (!stat.out_busy)
                begin
                    state_next = mvrm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mvrm_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            mvrm_pkg::S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                cmd.latch    = in_valid;
            end
            mvrm_pkg::S_DECODE:
            begin
                case (stat.mode)
                    mvrm_pkg::MODE_WRITE:  cmd.mem_wr    = 1'b1;
                    mvrm_pkg::MODE_START:  cmd.div_start = !stat.no_free;
                    mvrm_pkg::MODE_MIX:    cmd.mix_init  = 1'b1;
                    mvrm_pkg::MODE_VOLUME,
                    mvrm_pkg::MODE_STOP,
                    mvrm_pkg::MODE_PAUSE,
                    mvrm_pkg::MODE_RESUME: cmd.voice_cmd = 1'b1;
                    default:               cmd.voice_cmd = 1'b0;
                endcase
            end
            mvrm_pkg::S_DIV_STEP: cmd.step_load = stat.div_done;
            mvrm_pkg::S_MOD_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_mod   = 1'b1;
            end
            mvrm_pkg::S_DIV_MOD:  cmd.stepm_load = stat.div_done;
            mvrm_pkg::S_COMMIT:   cmd.commit = 1'b1;
            mvrm_pkg::S_CHK:      cmd.voice_next = !stat.voice_live && !stat.last_voice;
            mvrm_pkg::S_RD0:
            begin
                cmd.rd_en    = 1'b1;
                cmd.word_sel = 1'b0;
            end
            mvrm_pkg::S_RD1:
            begin
                cmd.rd_en    = 1'b1;
                cmd.word_sel = 1'b1;
                cmd.cap_s0   = 1'b1;
            end
            mvrm_pkg::S_CAP:   cmd.cap_s1 = 1'b1;
            mvrm_pkg::S_PROD:  cmd.prod   = 1'b1;
            mvrm_pkg::S_GAIN:  cmd.gain   = 1'b1;
            mvrm_pkg::S_RECIP: cmd.recip  = 1'b1;
            mvrm_pkg::S_ACC:
            begin
                cmd.acc      = 1'b1;
                cmd.side_set = stat.voice_stereo && !stat.side;
            end
            mvrm_pkg::S_ADV:
            begin
                cmd.adv        = 1'b1;
                cmd.voice_next = !stat.last_voice;
            end
            mvrm_pkg::S_RESP: cmd.resp_load = !stat.out_busy;
            default:          cmd.in_ready  = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

[rtl/mvrm_dp.sv]
// datapath of the mixer: sample memory, voice table, interpolation and mix sums
// depends on mvrm_pkg and mvrm_div
`timescale 1ns / 1ps
`default_nettype none

module mvrm_dp (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire mvrm_pkg::mvrm_cmd_t                 cmd,
    output mvrm_pkg::mvrm_stat_t                     stat,
    input  wire logic                                cfg_we,
    input  wire logic [mvrm_pkg::RATE_W-1:0]         cfg_rate,
    input  wire logic [2:0]                          in_mode,
    input  wire logic [mvrm_pkg::ADDR_W-1:0]         in_address,
    input  wire logic [mvrm_pkg::SAMPLE_W-1:0]       in_sample,
    input  wire logic [mvrm_pkg::LEN_W-1:0]          in_length,
    input  wire logic                                in_stereo,
    input  wire logic [mvrm_pkg::RATE_W-1:0]         in_srate,
    input  wire logic                                in_loop,
    input  wire logic [mvrm_pkg::GAIN_W-1:0]         in_volume,
    input  wire logic [mvrm_pkg::VIDX_W-1:0]         in_voice,
    input  wire logic                                out_ready,
    output logic                                     out_valid,
    output logic signed [mvrm_pkg::OUT_W-1:0]        out_left,
    output logic signed [mvrm_pkg::OUT_W-1:0]        out_right,
    output logic [mvrm_pkg::VIDX_W-1:0]              out_slot,
    output logic [1:0]                               out_status,
    output logic [mvrm_pkg::MASK_W-1:0]              out_mask
);

    localparam int VOICES = mvrm_pkg::VOICES;
    localparam int FB     = mvrm_pkg::FRAC_BITS;

    // configuration
    logic [mvrm_pkg::RATE_W-1:0] rate_reg;

    // latched item
    mvrm_pkg::mode_t               mode_reg;
    logic [mvrm_pkg::ADDR_W-1:0]   addr_reg;
    logic [mvrm_pkg::SAMPLE_W-1:0] sval_reg;
    logic [mvrm_pkg::LEN_W-1:0]    len_reg;
    logic                          st_reg;
    logic [mvrm_pkg::RATE_W-1:0]   srate_reg;
    logic                          loop_reg;
    logic [mvrm_pkg::GAIN_W-1:0]   vol_reg;
    logic [mvrm_pkg::VIDX_W-1:0]   vsel_reg;
    logic                          nofree_reg;
    logic                          bad_reg;
    logic [mvrm_pkg::VIDX_W-1:0]   fslot_reg;

    // voice table
    logic [VOICES-1:0]               active_reg;
    logic [VOICES-1:0]               paused_reg;
    logic [VOICES-1:0]               looping_reg;
    logic [VOICES-1:0]               vstereo_reg;
    logic [mvrm_pkg::ADDR_W-1:0]     vstart_reg [VOICES];
    logic [mvrm_pkg::FRAMES_W-1:0]   vtotal_reg [VOICES];
    logic [mvrm_pkg::GAIN_W-1:0]     vgain_reg  [VOICES];
    logic [mvrm_pkg::POS_W-1:0]      vpos_reg   [VOICES];
    logic [mvrm_pkg::STEP_W-1:0]     vstep_reg  [VOICES];

    logic [mvrm_pkg::STEP_W-1:0]     step_reg;

    // sample memory
    logic [mvrm_pkg::SAMPLE_W-1:0]   mem [mvrm_pkg::SAMPLE_WORDS];
    logic [mvrm_pkg::SAMPLE_W-1:0]   rdata_reg;
    logic [mvrm_pkg::ADDR_W-1:0]     rd_addr;

    // mix sequencing and arithmetic
    logic [mvrm_pkg::VIDX_W-1:0]         vidx_reg;
    logic                                side_reg;
    logic signed [mvrm_pkg::SAMPLE_W-1:0] s0_reg, s1_reg;
    logic signed [mvrm_pkg::PROD_W-1:0]  p0_reg, p1_reg;
    logic signed [mvrm_pkg::GPROD_W-1:0] q_reg;
    logic [mvrm_pkg::RECIP_W-1:0]        r_reg;
    logic                                neg2_reg;
    logic signed [mvrm_pkg::ACC_W-1:0]   accl_reg, accr_reg;

    // output register
    logic                                oval_reg;
    logic signed [mvrm_pkg::OUT_W-1:0]   oleft_reg, oright_reg;
    logic [mvrm_pkg::VIDX_W-1:0]         oslot_reg;
    logic [1:0]                          ostatus_reg;
    logic [mvrm_pkg::MASK_W-1:0]         omask_reg;

    // divider
    logic [mvrm_pkg::DIVD_W-1:0] div_dividend;
    logic [mvrm_pkg::DIVS_W-1:0] div_divisor;
    logic [mvrm_pkg::DIVD_W-1:0] div_quo;
    logic [mvrm_pkg::DIVS_W-1:0] div_rem;
    logic                        div_done;

    // combinational helpers
    logic                          free_any;
    logic [mvrm_pkg::VIDX_W-1:0]   free_idx;
    logic [mvrm_pkg::FRAMES_W-1:0] total_new;
    logic [mvrm_pkg::GAIN_W-1:0]   gain_new;
    logic [mvrm_pkg::POS_W-1:0]    pos_cur;
    logic [mvrm_pkg::FRAMES_W-1:0] total_cur;
    logic [mvrm_pkg::FRAMES_W-1:0] f0, f0p1, f1, fsel;
    logic [FB-1:0]                 frac;
    logic [FB:0]                   wfrac;
    logic [mvrm_pkg::ADDR_W-1:0]   off;
    logic signed [mvrm_pkg::PROD_W-1:0]  x_sum;
    logic [mvrm_pkg::GPROD_W-1:0]        q_mag;
    logic [mvrm_pkg::CONTRIB_W-1:0]      t_mag;
    logic signed [mvrm_pkg::ACC_W-1:0]   contrib;
    logic [mvrm_pkg::POS_W:0]            adv_sum;
    logic [mvrm_pkg::POS_W:0]            adv_lim;
    logic signed [mvrm_pkg::OUT_W-1:0]   left_cl, right_cl;

    // lowest free slot
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int k = VOICES - 1; k >= 0; k--)
        begin
            if (!active_reg[k])
            begin
                free_any = 1'b1;
                free_idx = mvrm_pkg::VIDX_W'(k);
            end
        end
    end

    assign total_new = st_reg ? {1'b0, len_reg[mvrm_pkg::LEN_W-1:1]} : len_reg;
    assign gain_new  = (vol_reg > mvrm_pkg::GAIN_W'(mvrm_pkg::GAIN_MAX))
                       ? mvrm_pkg::GAIN_W'(mvrm_pkg::GAIN_MAX) : vol_reg;

    assign div_dividend = cmd.div_mod
        ? {{(mvrm_pkg::DIVD_W - mvrm_pkg::STEP_W + FB){1'b0}}, step_reg[mvrm_pkg::STEP_W-1:FB]}
        : {srate_reg, {FB{1'b0}}};
    assign div_divisor = cmd.div_mod ? mvrm_pkg::DIVS_W'(total_new)
                       : ((rate_reg == '0) ? mvrm_pkg::DIVS_W'(1) : rate_reg);

    mvrm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quo),
        .remainder (div_rem),
        .done      (div_done)
    );

    // current voice fetch
    assign pos_cur   = vpos_reg[vidx_reg];
    assign total_cur = vtotal_reg[vidx_reg];
    assign f0        = pos_cur[FB +: mvrm_pkg::FRAMES_W];
    assign f0p1      = f0 + 1'b1;
    assign frac      = pos_cur[FB-1:0];
    assign wfrac     = (FB+1)'(1 << FB) - {1'b0, frac};

    always_comb
    begin
        if (looping_reg[vidx_reg])
        begin
            f1 = (f0p1 == total_cur) ? '0 : f0p1;
        end
        else
        begin
            f1 = (f0p1 < total_cur) ? f0p1 : total_cur - 1'b1;
        end
    end

    assign fsel    = cmd.word_sel ? f1 : f0;
    assign off     = vstereo_reg[vidx_reg] ? {fsel[mvrm_pkg::ADDR_W-2:0], side_reg}
                                           : fsel[mvrm_pkg::ADDR_W-1:0];
    assign rd_addr = vstart_reg[vidx_reg] + off;

    assign x_sum   = p0_reg + p1_reg;
    assign q_mag   = q_reg[mvrm_pkg::GPROD_W-1] ? mvrm_pkg::GPROD_W'(-q_reg)
                                                : mvrm_pkg::GPROD_W'(q_reg);
    assign t_mag   = r_reg[mvrm_pkg::RECIP_SH +: mvrm_pkg::CONTRIB_W];
    assign contrib = neg2_reg ? -$signed({3'b0, t_mag}) : $signed({3'b0, t_mag});

    assign adv_sum = {1'b0, pos_cur} + (mvrm_pkg::POS_W+1)'(vstep_reg[vidx_reg]);
    assign adv_lim = {1'b0, total_cur, {FB{1'b0}}};

    always_comb
    begin
        if (accl_reg > mvrm_pkg::ACC_W'(mvrm_pkg::OUT_MAX))
            left_cl = mvrm_pkg::OUT_W'(mvrm_pkg::OUT_MAX);
        else if (accl_reg < mvrm_pkg::ACC_W'(mvrm_pkg::OUT_MIN))
            left_cl = mvrm_pkg::OUT_W'(mvrm_pkg::OUT_MIN);
        else
            left_cl = accl_reg[mvrm_pkg::OUT_W-1:0];
        if (accr_reg > mvrm_pkg::ACC_W'(mvrm_pkg::OUT_MAX))
            right_cl = mvrm_pkg::OUT_W'(mvrm_pkg::OUT_MAX);
        else if (accr_reg < mvrm_pkg::ACC_W'(mvrm_pkg::OUT_MIN))
            right_cl = mvrm_pkg::OUT_W'(mvrm_pkg::OUT_MIN);
        else
            right_cl = accr_reg[mvrm_pkg::OUT_W-1:0];
    end

    // memory
    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
        begin
            mem[addr_reg] <= sval_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // control state of the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg   <= mvrm_pkg::RATE_W'(mvrm_pkg::RATE_RESET);
            active_reg <= '0;
            paused_reg <= '0;
            oval_reg   <= 1'b0;
            vidx_reg   <= '0;
            side_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                rate_reg <= cfg_rate;
            end
            if (cmd.voice_cmd && !bad_reg)
            begin
                case (mode_reg)
                    mvrm_pkg::MODE_STOP:
                    begin
                        active_reg[vsel_reg] <= 1'b0;
                        paused_reg[vsel_reg] <= 1'b0;
                    end
                    mvrm_pkg::MODE_PAUSE:  paused_reg[vsel_reg] <= 1'b1;
                    mvrm_pkg::MODE_RESUME: paused_reg[vsel_reg] <= 1'b0;
                    default:               paused_reg <= paused_reg;
                endcase
            end
            if (cmd.commit)
            begin
                active_reg[fslot_reg] <= 1'b1;
                paused_reg[fslot_reg] <= 1'b0;
            end
            // one-shot voice that runs past its last frame frees its slot
            if (cmd.adv && !looping_reg[vidx_reg] && adv_sum >= adv_lim)
            begin
                active_reg[vidx_reg] <= 1'b0;
                paused_reg[vidx_reg] <= 1'b0;
            end
            if (cmd.mix_init)
            begin
                vidx_reg <= '0;
                side_reg <= 1'b0;
            end
            else if (cmd.voice_next)
            begin
                vidx_reg <= vidx_reg + 1'b1;
                side_reg <= 1'b0;
            end
            else if (cmd.side_set)
            begin
                side_reg <= 1'b1;
            end
            if (cmd.resp_load)
            begin
                oval_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                oval_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            mode_reg   <= mvrm_pkg::mode_t'(in_mode);
            addr_reg   <= in_address;
            sval_reg   <= in_sample;
            len_reg    <= in_length;
            st_reg     <= in_stereo;
            srate_reg  <= in_srate;
            loop_reg   <= in_loop;
            vol_reg    <= in_volume;
            vsel_reg   <= in_voice;
            nofree_reg <= !free_any;
            fslot_reg  <= free_idx;
            bad_reg    <= !active_reg[in_voice];
        end
        if (cmd.voice_cmd && !bad_reg && mode_reg == mvrm_pkg::MODE_VOLUME)
        begin
            vgain_reg[vsel_reg] <= gain_new;
        end
        if (cmd.step_load)
        begin
            step_reg <= (div_quo[mvrm_pkg::DIVD_W-1:mvrm_pkg::STEP_W] != '0)
                        ? '1 : div_quo[mvrm_pkg::STEP_W-1:0];
        end
        // looping voices keep the step reduced modulo the clip length
        if (cmd.stepm_load)
        begin
            step_reg <= {div_rem[FB-1:0], step_reg[FB-1:0]};
        end
        if (cmd.commit)
        begin
            looping_reg[fslot_reg] <= loop_reg;
            vstereo_reg[fslot_reg] <= st_reg;
            vstart_reg[fslot_reg]  <= addr_reg;
            vtotal_reg[fslot_reg]  <= total_new;
            vgain_reg[fslot_reg]   <= gain_new;
            vpos_reg[fslot_reg]    <= '0;
            vstep_reg[fslot_reg]   <= step_reg;
        end
        if (cmd.adv)
        begin
            if (looping_reg[vidx_reg] && adv_sum >= adv_lim)
                vpos_reg[vidx_reg] <= mvrm_pkg::POS_W'(adv_sum - adv_lim);
            else
                vpos_reg[vidx_reg] <= adv_sum[mvrm_pkg::POS_W-1:0];
        end
        if (cmd.cap_s0)
        begin
            s0_reg <= $signed(rdata_reg);
        end
        if (cmd.cap_s1)
        begin
            s1_reg <= $signed(rdata_reg);
        end
        if (cmd.prod)
        begin
            p0_reg <= s0_reg * $signed({1'b0, wfrac});
            p1_reg <= s1_reg * $signed({1'b0, frac});
        end
        if (cmd.gain)
        begin
            q_reg <= x_sum * $signed({1'b0, vgain_reg[vidx_reg]});
        end
        // divide by 100 * 2^16: drop the fraction, then reciprocal of 100
        if (cmd.recip)
        begin
            r_reg    <= {{(mvrm_pkg::RECIP_W - mvrm_pkg::Y_W){1'b0}},
                         q_mag[FB +: mvrm_pkg::Y_W]} * mvrm_pkg::RECIP_W'(mvrm_pkg::RECIP_M);
            neg2_reg <= q_reg[mvrm_pkg::GPROD_W-1];
        end
        if (cmd.mix_init)
        begin
            accl_reg <= '0;
            accr_reg <= '0;
        end
        else if (cmd.acc)
        begin
            if (!vstereo_reg[vidx_reg] || !side_reg)
                accl_reg <= accl_reg + contrib;
            if (!vstereo_reg[vidx_reg] || side_reg)
                accr_reg <= accr_reg + contrib;
        end
        if (cmd.resp_load)
        begin
            oleft_reg   <= (mode_reg == mvrm_pkg::MODE_MIX) ? left_cl : '0;
            oright_reg  <= (mode_reg == mvrm_pkg::MODE_MIX) ? right_cl : '0;
            oslot_reg   <= (mode_reg == mvrm_pkg::MODE_START && !nofree_reg) ? fslot_reg : '0;
            omask_reg   <= mvrm_pkg::MASK_W'(active_reg);
            if (mode_reg == mvrm_pkg::MODE_START && nofree_reg)
                ostatus_reg <= mvrm_pkg::ST_NO_FREE;
            else if ((mode_reg == mvrm_pkg::MODE_VOLUME || mode_reg == mvrm_pkg::MODE_STOP ||
                      mode_reg == mvrm_pkg::MODE_PAUSE || mode_reg == mvrm_pkg::MODE_RESUME)
                     && bad_reg)
                ostatus_reg <= mvrm_pkg::ST_NOT_ACTIVE;
            else
                ostatus_reg <= mvrm_pkg::ST_OK;
        end
    end

    always_comb
    begin
        stat              = '0;
        stat.mode         = mode_reg;
        stat.no_free      = nofree_reg;
        stat.div_done     = div_done;
        stat.loop_mod     = loop_reg && (total_new != '0);
        stat.voice_live   = active_reg[vidx_reg] && !paused_reg[vidx_reg] && (total_cur != '0);
        stat.voice_stereo = vstereo_reg[vidx_reg];
        stat.side         = side_reg;
        stat.last_voice   = (vidx_reg == mvrm_pkg::VIDX_W'(VOICES - 1));
        stat.out_busy     = oval_reg && !out_ready;
    end

    assign out_valid  = oval_reg;
    assign out_left   = oleft_reg;
    assign out_right  = oright_reg;
    assign out_slot   = oslot_reg;
    assign out_status = ostatus_reg;
    assign out_mask   = omask_reg;

endmodule

`default_nettype wire

[rtl/multi_voice_resampling_mixer_unit.sv]
// top level of the eight-voice resampling mixer with its channel interfaces
// depends on mvrm_pkg, mvrm_if, mvrm_ctrl and mvrm_dp
`timescale 1ns / 1ps
`default_nettype none

// Eight-voice sample mixer: clips live in a 64K-word sample memory, each voice
// steps through its clip at source_rate * 65536 / output_rate and is linearly
// interpolated, scaled by its volume percent and summed into one clamped stereo
// frame per mix item. One item is handled at a time. A start item runs the
// bit-serial step division, and a second division when the clip loops, to reduce
// the step modulo the clip length; a mix item skips voices that are not playing
// and reads each playing voice through the single sample memory read port, once
// per channel for stereo. The result waits in an output register, and the next
// item is taken as soon as the sequencer is back in idle.
module multi_voice_resampling_mixer_unit (
    input  wire logic     clk,
    input  wire logic     rst_n,
    mvrm_in_if.sink       in_ch,
    mvrm_out_if.source    out_ch,
    mvrm_cfg_if.sink      cfg_ch
);

    mvrm_pkg::mvrm_cmd_t  cmd;
    mvrm_pkg::mvrm_stat_t stat;

    assign in_ch.ready  = cmd.in_ready;
    assign cfg_ch.ready = 1'b1;

    mvrm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .stat     (stat),
        .cmd      (cmd)
    );

    mvrm_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_we     (cfg_ch.valid),
        .cfg_rate   (cfg_ch.output_rate),
        .in_mode    (in_ch.mode),
        .in_address (in_ch.address),
        .in_sample  (in_ch.sample_value),
        .in_length  (in_ch.length_words),
        .in_stereo  (in_ch.stereo),
        .in_srate   (in_ch.source_rate),
        .in_loop    (in_ch.loop_enable),
        .in_volume  (in_ch.volume),
        .in_voice   (in_ch.voice),
        .out_ready  (out_ch.ready),
        .out_valid  (out_ch.valid),
        .out_left   (out_ch.left_sample),
        .out_right  (out_ch.right_sample),
        .out_slot   (out_ch.slot),
        .out_status (out_ch.status),
        .out_mask   (out_ch.playing_mask)
    );

`ifndef SYNTH
    // no free slot only when every slot is playing
    a_nofree_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.status == mvrm_pkg::ST_NO_FREE) |-> (&out_ch.playing_mask))
        else $error("no-free status with an idle slot");

    // a failed command carries no samples and no slot
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.status != mvrm_pkg::ST_OK) |->
        (out_ch.left_sample == '0 && out_ch.right_sample == '0 && out_ch.slot == '0))
        else $error("error result carries payload");

    // no new item is taken while the sequencer still owes a result
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("item accepted while busy");
`endif

endmodule

`default_nettype wire
